@@ rtl/core/orbit_camera_position_smoother_macros.svh @@
// Assertion macros used by the checker module of the orbit camera block.
`ifndef ORBIT_CAMERA_POSITION_SMOOTHER_MACROS_SVH
`define ORBIT_CAMERA_POSITION_SMOOTHER_MACROS_SVH

// Check prop at every rising clock edge, skip while reset is high.
`define OCPS_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check prop at every rising clock edge, reset included.
`define OCPS_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/ocps_pkg.sv @@
// Shared types, constants and sine table builder for the orbit camera block.
`default_nettype none
package ocps_pkg;

  localparam int SINE_TABLE_BITS_DEF = 10;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_SPEED     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PITCH_MIN       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PITCH_MAX       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ORBIT_RADIUS    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_HEIGHT   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SMOOTH_FRACTION = 3'd5;

  // Register reset values
  localparam logic [15:0]        ANGLE_SPEED_RST     = 16'd364;
  localparam logic signed [15:0] PITCH_MIN_RST       = -16'sd5461;
  localparam logic signed [15:0] PITCH_MAX_RST       = 16'sd10923;
  localparam logic [30:0]        ORBIT_RADIUS_RST    = 31'd65536000;
  localparam logic signed [31:0] TARGET_HEIGHT_RST   = 32'sd6553600;
  localparam logic [15:0]        SMOOTH_FRACTION_RST = 16'd6554;

  localparam logic [15:0] QUARTER_TURN = 16'h4000;

  // pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Operands of the shared multiplier
  typedef struct packed {
    logic signed [32:0] a;
    logic signed [17:0] b;
  } mul_op_t;

  // Quarter-wave sine entry k, Q16, from a Q30 Taylor series rounded half up.
  function automatic logic [16:0] qsine_entry(input int unsigned k, input int unsigned bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] s;
    logic signed [63:0] r;
    x  = (64'(k) * HALF_PI_Q30) >> (bits - 2);
    x2 = (x * x) >> 30;
    s  = $signed(x);
    t  = ((x * x2) >> 30) / 6;   s = s - $signed(t);
    t  = ((t * x2) >> 30) / 20;  s = s + $signed(t);
    t  = ((t * x2) >> 30) / 42;  s = s - $signed(t);
    t  = ((t * x2) >> 30) / 72;  s = s + $signed(t);
    t  = ((t * x2) >> 30) / 110; s = s - $signed(t);
    t  = ((t * x2) >> 30) / 156; s = s + $signed(t);
    t  = ((t * x2) >> 30) / 210; s = s - $signed(t);
    t  = ((t * x2) >> 30) / 272; s = s + $signed(t);
    t  = ((t * x2) >> 30) / 342; s = s - $signed(t);
    t  = ((t * x2) >> 30) / 420; s = s + $signed(t);
    if (s < 0) begin
      s = 0;
    end
    r = (s + 64'sd8192) >>> 14;
    if (r > 64'sd65536) begin
      r = 64'sd65536;
    end
    return r[16:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/ocps_mul.sv @@
// Shared signed multiplier with a registered product.
`default_nettype none
module ocps_mul (
  input  wire                    clk,
  input  wire ocps_pkg::mul_op_t op,
  output logic signed [50:0]     prod
);
  import ocps_pkg::*;

  always_ff @(posedge clk) begin
    prod <= 51'(op.a * op.b);
  end

endmodule
`default_nettype wire

@@ rtl/core/ocps_sine.sv @@
// Sine lookup from a quarter-wave constant table, registered output in Q16.
`default_nettype none
module ocps_sine #(
  parameter int SINE_TABLE_BITS = ocps_pkg::SINE_TABLE_BITS_DEF
) (
  input  wire                   clk,
  input  wire        [15:0]     angle,
  output logic signed [17:0]    sine
);
  import ocps_pkg::*;

  localparam int QSTEPS = 1 << (SINE_TABLE_BITS - 2);
  localparam int ADDR_W = SINE_TABLE_BITS - 1;

  logic [16:0]                 qtab [QSTEPS+1];
  logic [SINE_TABLE_BITS-1:0]  idx;
  logic [1:0]                  quad;
  logic [SINE_TABLE_BITS-3:0]  frac;
  logic [ADDR_W-1:0]           addr;
  logic [16:0]                 mag;

  for (genvar k = 0; k <= QSTEPS; k++) begin : g_tab
    assign qtab[k] = qsine_entry(k, SINE_TABLE_BITS);
  end

  always_comb begin
    idx  = angle[15 -: SINE_TABLE_BITS];
    quad = idx[SINE_TABLE_BITS-1 -: 2];
    frac = idx[SINE_TABLE_BITS-3:0];
    // mirror the quarter wave in odd quadrants
    addr = quad[0] ? (ADDR_W'(QSTEPS) - {1'b0, frac}) : {1'b0, frac};
    mag  = qtab[addr];
  end

  always_ff @(posedge clk) begin
    if (quad[1]) begin
      sine <= -$signed({1'b0, mag});
    end else begin
      sine <= $signed({1'b0, mag});
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/orbit_camera_position_smoother.sv @@
// Orbit camera position smoother: top level with sequencer and registers.
// Usage:
//   One beat on the s_axis channel carries one joystick sample per frame. The block
//   updates yaw and pitch, places the orbit point on a sphere around the target and
//   moves the stored camera position toward it; the new position leaves as one beat
//   on the m_axis channel.
//   All multiplications go through one shared 33x18 multiplier, one product per cycle,
//   under a sequencer that walks 13 work steps and then waits in an output step until
//   the output register is free; no new sample is taken before it has finished the last.
//   s_axis_tready is high only while the sequencer is idle.
//   The output register holds a finished result; the next sample may be taken while
//   it waits. If the receiver still stalls when the following result is ready, the
//   sequencer holds there until the output register is free.
//   Reset (rst, synchronous) clears yaw, pitch and position to zero, loads the
//   register defaults and drops m_axis_tvalid.
//   Configuration writes land on the edge where cfg_wr_en is high; write only while
//   idle. Unknown indexes are ignored.
`default_nettype none
module orbit_camera_position_smoother #(
  parameter int SINE_TABLE_BITS = ocps_pkg::SINE_TABLE_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [31:0]                        s_axis_tdata,  // stick_x[15:0], stick_y[31:16]
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [95:0]                        m_axis_tdata,  // cam_x[31:0], cam_y[63:32], cam_z[95:64]
  input  wire                                cfg_wr_en,
  input  wire  [ocps_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire  [ocps_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ocps_pkg::*;

  typedef enum logic [14:0] {
    ST_IDLE  = 15'b000000000000001,
    ST_DX    = 15'b000000000000010,
    ST_DY    = 15'b000000000000100,
    ST_PITCH = 15'b000000000001000,
    ST_CP    = 15'b000000000010000,
    ST_MH    = 15'b000000000100000,
    ST_MSP   = 15'b000000001000000,
    ST_MTX   = 15'b000000010000000,
    ST_MTZ   = 15'b000000100000000,
    ST_TZ    = 15'b000001000000000,
    ST_S0    = 15'b000010000000000,
    ST_S1    = 15'b000100000000000,
    ST_S2    = 15'b001000000000000,
    ST_P2    = 15'b010000000000000,
    ST_OUT   = 15'b100000000000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [15:0]        angle_speed;
  logic signed [15:0] pitch_min;
  logic signed [15:0] pitch_max;
  logic [30:0]        orbit_radius;
  logic signed [31:0] target_height;
  logic [15:0]        smooth_fraction;

  logic signed [15:0] stick_x;
  logic signed [15:0] stick_y;
  logic [15:0]        yaw;
  logic signed [15:0] pitch;
  logic signed [31:0] pos0, pos1, pos2;
  logic signed [31:0] t0, t1, t2;
  logic signed [31:0] h;
  logic signed [31:0] cam_x, cam_y, cam_z;

  mul_op_t            mop;
  logic signed [50:0] prod;
  logic [15:0]        sin_angle;
  logic signed [17:0] sine;

  logic signed [18:0] pitch_sum;
  logic signed [18:0] pitch_lo;
  logic signed [18:0] pitch_clamped;
  logic signed [32:0] height_sum;
  logic signed [31:0] height_sat;
  logic signed [32:0] d0, d1, d2;
  logic signed [34:0] step_q;
  logic signed [34:0] pos_sum0, pos_sum1, pos_sum2;
  logic               out_free;

  ocps_mul u_mul (
    .clk  (clk),
    .op   (mop),
    .prod (prod)
  );

  ocps_sine #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_sine (
    .clk   (clk),
    .angle (sin_angle),
    .sine  (sine)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tdata  = {cam_z, cam_y, cam_x};
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_speed     <= ANGLE_SPEED_RST;
      pitch_min       <= PITCH_MIN_RST;
      pitch_max       <= PITCH_MAX_RST;
      orbit_radius    <= ORBIT_RADIUS_RST;
      target_height   <= TARGET_HEIGHT_RST;
      smooth_fraction <= SMOOTH_FRACTION_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ANGLE_SPEED:     angle_speed     <= cfg_data[15:0];
        REG_PITCH_MIN:       pitch_min       <= $signed(cfg_data[15:0]);
        REG_PITCH_MAX:       pitch_max       <= $signed(cfg_data[15:0]);
        REG_ORBIT_RADIUS:    orbit_radius    <= cfg_data[30:0];
        REG_TARGET_HEIGHT:   target_height   <= $signed(cfg_data);
        REG_SMOOTH_FRACTION: smooth_fraction <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Datapath helpers
  always_comb begin
    pitch_sum = 19'(pitch) + 19'($signed(prod[32:15]));
    pitch_lo  = (pitch_sum < 19'(pitch_min)) ? 19'(pitch_min) : pitch_sum;
    pitch_clamped = (pitch_lo > 19'(pitch_max)) ? 19'(pitch_max) : pitch_lo;

    height_sum = 33'($signed(prod[47:16])) + 33'(target_height);
    if (height_sum > 33'sh0_7FFF_FFFF) begin
      height_sat = 32'sh7FFF_FFFF;
    end else if (height_sum < -33'sh0_8000_0000) begin
      height_sat = 32'sh8000_0000;
    end else begin
      height_sat = height_sum[31:0];
    end

    d0 = 33'(t0) - 33'(pos0);
    d1 = 33'(t1) - 33'(pos1);
    d2 = 33'(t2) - 33'(pos2);

    step_q   = $signed(prod[50:16]);
    pos_sum0 = 35'(pos0) + step_q;
    pos_sum1 = 35'(pos1) + step_q;
    pos_sum2 = 35'(pos2) + step_q;
  end

  // Operand and angle selection per step
  always_comb begin
    mop.a     = '0;
    mop.b     = '0;
    sin_angle = yaw;
    case (state)
      ST_DX: begin
        mop.a = $signed({17'd0, angle_speed});
        mop.b = 18'(stick_x);
      end
      ST_DY: begin
        mop.a = $signed({17'd0, angle_speed});
        mop.b = 18'(stick_y);
      end
      ST_CP: begin
        sin_angle = pitch + QUARTER_TURN;
      end
      ST_MH: begin
        mop.a     = $signed({2'd0, orbit_radius});
        mop.b     = sine;
        sin_angle = pitch;
      end
      ST_MSP: begin
        mop.a     = $signed({2'd0, orbit_radius});
        mop.b     = sine;
        sin_angle = yaw;
      end
      ST_MTX: begin
        mop.a     = 33'(h);
        mop.b     = sine;
        sin_angle = yaw + QUARTER_TURN;
      end
      ST_MTZ: begin
        mop.a = 33'(h);
        mop.b = sine;
      end
      ST_S0: begin
        mop.a = d0;
        mop.b = $signed({2'd0, smooth_fraction});
      end
      ST_S1: begin
        mop.a = d1;
        mop.b = $signed({2'd0, smooth_fraction});
      end
      ST_S2: begin
        mop.a = d2;
        mop.b = $signed({2'd0, smooth_fraction});
      end
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_axis_tvalid) state_next = ST_DX;
      ST_DX:    state_next = ST_DY;
      ST_DY:    state_next = ST_PITCH;
      ST_PITCH: state_next = ST_CP;
      ST_CP:    state_next = ST_MH;
      ST_MH:    state_next = ST_MSP;
      ST_MSP:   state_next = ST_MTX;
      ST_MTX:   state_next = ST_MTZ;
      ST_MTZ:   state_next = ST_TZ;
      ST_TZ:    state_next = ST_S0;
      ST_S0:    state_next = ST_S1;
      ST_S1:    state_next = ST_S2;
      ST_S2:    state_next = ST_P2;
      ST_P2:    state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Angle and position state
  always_ff @(posedge clk) begin
    if (rst) begin
      yaw   <= '0;
      pitch <= '0;
      pos0  <= '0;
      pos1  <= '0;
      pos2  <= '0;
    end else begin
      case (state)
        ST_DY:    yaw   <= yaw - prod[30:15];
        ST_PITCH: pitch <= pitch_clamped[15:0];
        ST_S1:    pos0  <= pos_sum0[31:0];
        ST_S2:    pos1  <= pos_sum1[31:0];
        ST_P2:    pos2  <= pos_sum2[31:0];
        default: ;
      endcase
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      stick_x <= $signed(s_axis_tdata[15:0]);
      stick_y <= $signed(s_axis_tdata[31:16]);
    end
    case (state)
      ST_MSP: h  <= $signed(prod[47:16]);
      ST_MTX: t1 <= height_sat;
      ST_MTZ: t0 <= $signed(prod[47:16]);
      ST_TZ:  t2 <= -$signed(prod[47:16]);
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      cam_x <= pos0;
      cam_y <= pos1;
      cam_z <= pos2;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/ocps_checker.sv @@
// Port-level checker for the orbit camera block, bound to the top level.
`default_nettype none
`include "orbit_camera_position_smoother_macros.svh"
module ocps_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [95:0] m_axis_tdata
);

  // Reset drops the result beat.
  `OCPS_ASSERT(a_rst_no_out, clk, rst |=> !m_axis_tvalid, "result valid after reset")

  // One sample at a time: input closes after a beat is taken.
  `OCPS_ASSERT_RST(a_one_item, clk, rst, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "input open while busy")

  // A result never appears on the cycle right after a sample is taken.
  `OCPS_ASSERT_RST(a_no_early_out, clk, rst, (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid), "result too early")

  // Hold a stalled result beat.
  `OCPS_ASSERT_RST(a_out_hold, clk, rst, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

endmodule

bind orbit_camera_position_smoother ocps_checker u_ocps_checker (.*);
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the orbit camera position smoother.
`timescale 1ns / 100ps
module tb;
  import ocps_pkg::*;

  localparam int TABLE_BITS = SINE_TABLE_BITS_DEF;
  localparam int QSTEPS = 1 << (TABLE_BITS - 2);
  localparam int SETTLE_CYCLES = 24;
  localparam int ITEMS_PER_SETTING = 134;
  localparam int SETTINGS_PER_PHASE = 4;
  localparam int MAX_REPORTS = 10;
  // Indexes past the last register; writes there must change nothing
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } cam_pos_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // stick_x[15:0], stick_y[31:16]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;       // cam_x[31:0], cam_y[63:32], cam_z[95:64]
  logic cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Register copies and frame state of the predictor
  logic [15:0]        speed_cfg;
  logic signed [15:0] pitch_lo_cfg;
  logic signed [15:0] pitch_hi_cfg;
  logic [30:0]        radius_cfg;
  logic signed [31:0] height_cfg;
  logic [15:0]        smooth_cfg;
  logic [15:0]        yaw_st;
  logic signed [15:0] pitch_st;
  longint             pos_st [3];
  longint             qsine [0:QSTEPS];

  cam_pos_t pending_positions[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int frames_sent = 0;
  int positions_checked = 0;
  int settings_used = 0;
  int failures = 0;

  orbit_camera_position_smoother #(
    .SINE_TABLE_BITS(TABLE_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Quarter wave in Q16 from a Q30 Taylor series, rounded half up
  function automatic void build_sine_table();
    longint unsigned x, x2, term;
    longint sum, r;
    int k, n;
    for (k = 0; k <= QSTEPS; k++) begin
      x = (longint'(k) * HALF_PI_Q30) / QSTEPS;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (n = 1; n <= 10; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = (sum + 8192) >>> 14;
      if (r > 65536) begin
        r = 65536;
      end
      qsine[k] = r;
    end
  endfunction

  function automatic longint sine_at(input logic [15:0] ang);
    int unsigned idx, quad, step;
    longint v;
    idx = ang >> (16 - TABLE_BITS);
    quad = (idx >> (TABLE_BITS - 2)) & 3;
    step = idx & (QSTEPS - 1);
    v = (quad & 1) ? qsine[QSTEPS - step] : qsine[step];
    return (quad & 2) ? -v : v;
  endfunction

  function automatic longint clamp_q16(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic void load_reset_state();
    speed_cfg = ANGLE_SPEED_RST;
    pitch_lo_cfg = PITCH_MIN_RST;
    pitch_hi_cfg = PITCH_MAX_RST;
    radius_cfg = ORBIT_RADIUS_RST;
    height_cfg = TARGET_HEIGHT_RST;
    smooth_cfg = SMOOTH_FRACTION_RST;
    yaw_st = '0;
    pitch_st = '0;
    foreach (pos_st[i]) pos_st[i] = 0;
  endfunction

  // Advance the camera by one joystick sample and return the new position
  function automatic cam_pos_t next_camera_position(input logic signed [15:0] sx,
                                                    input logic signed [15:0] sy);
    longint dx, dy, p, sp, cp, syw, cyw, h, d;
    longint tgt [3];
    logic [15:0] pitch_cos_ang, yaw_cos_ang;
    cam_pos_t res;
    dx = (longint'(sx) * longint'(speed_cfg)) >>> 15;
    dy = (longint'(sy) * longint'(speed_cfg)) >>> 15;
    yaw_st = yaw_st - dx[15:0];
    p = longint'(pitch_st) + dy;
    if (p < longint'(pitch_lo_cfg)) begin
      p = longint'(pitch_lo_cfg);
    end
    if (p > longint'(pitch_hi_cfg)) begin
      p = longint'(pitch_hi_cfg);
    end
    pitch_st = p[15:0];
    pitch_cos_ang = pitch_st + QUARTER_TURN;
    yaw_cos_ang = yaw_st + QUARTER_TURN;
    sp = sine_at(pitch_st);
    cp = sine_at(pitch_cos_ang);
    syw = sine_at(yaw_st);
    cyw = sine_at(yaw_cos_ang);
    h = (cp * longint'(radius_cfg)) >>> 16;
    tgt[0] = (syw * h) >>> 16;
    tgt[1] = clamp_q16(((sp * longint'(radius_cfg)) >>> 16) + longint'(height_cfg));
    tgt[2] = -((cyw * h) >>> 16);
    for (int i = 0; i < 3; i++) begin
      d = tgt[i] - pos_st[i];
      pos_st[i] = clamp_q16(pos_st[i] + ((d * longint'(smooth_cfg)) >>> 16));
    end
    res.x = pos_st[0][31:0];
    res.y = pos_st[1][31:0];
    res.z = pos_st[2][31:0];
    return res;
  endfunction

  function automatic void check_axis(input string axis, input logic signed [31:0] want,
                                     input logic signed [31:0] got);
    if (want !== got) begin
      if (failures < MAX_REPORTS) begin
        $display("[%0t] position %0d: %s expected %0d, got %0d",
                 $time, positions_checked, axis, want, got);
      end
      failures++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    cam_pos_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_positions.size() == 0) begin
        if (failures < MAX_REPORTS) begin
          $display("[%0t] result beat with no frame waiting: x %0d y %0d z %0d",
                   $time, got.x, got.y, got.z);
        end
        failures++;
      end else begin
        want = pending_positions.pop_front();
        check_axis("cam_x", want.x, got.x);
        check_axis("cam_y", want.y, got.y);
        check_axis("cam_z", want.z, got.z);
        positions_checked++;
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_ANGLE_SPEED:     speed_cfg = val[15:0];
      REG_PITCH_MIN:       pitch_lo_cfg = val[15:0];
      REG_PITCH_MAX:       pitch_hi_cfg = val[15:0];
      REG_ORBIT_RADIUS:    radius_cfg = val[30:0];
      REG_TARGET_HEIGHT:   height_cfg = val;
      REG_SMOOTH_FRACTION: smooth_cfg = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Hold tvalid while the block is busy; predict once the beat is taken
  task automatic send_frame(input logic signed [15:0] sx, input logic signed [15:0] sy);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {sy, sx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_positions.push_back(next_camera_position(sx, sy));
    frames_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_positions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_stick();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2, 3: return 16'(int'($urandom_range(0, 4000)) - 2000);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic pick_random_settings();
    logic signed [15:0] lo, hi, tmp;
    case ($urandom_range(3))
      0: write_reg(REG_ANGLE_SPEED, 32'hFFFF);
      1: write_reg(REG_ANGLE_SPEED, $urandom_range(0, 65535));
      default: write_reg(REG_ANGLE_SPEED, $urandom_range(1, 3000));
    endcase
    lo = 16'(int'($urandom_range(0, 32768)) - 16384);
    hi = 16'(int'($urandom_range(0, 32768)) - 16384);
    // keep most limit pairs ordered, leave some crossed
    if (lo > hi && $urandom_range(4) != 0) begin
      tmp = lo;
      lo = hi;
      hi = tmp;
    end
    write_reg(REG_PITCH_MIN, 32'(lo));
    write_reg(REG_PITCH_MAX, 32'(hi));
    case ($urandom_range(3))
      0: write_reg(REG_ORBIT_RADIUS, 32'h7FFF_FFFF);
      1: write_reg(REG_ORBIT_RADIUS, $urandom);
      default: write_reg(REG_ORBIT_RADIUS, $urandom_range(0, 32'd13107200));
    endcase
    case ($urandom_range(5))
      0: write_reg(REG_TARGET_HEIGHT, 32'h7FFF_FFFF);
      1: write_reg(REG_TARGET_HEIGHT, 32'h8000_0000);
      default: write_reg(REG_TARGET_HEIGHT, $urandom);
    endcase
    case ($urandom_range(7))
      0: write_reg(REG_SMOOTH_FRACTION, 32'hFFFF);
      1: write_reg(REG_SMOOTH_FRACTION, 32'd0);
      default: write_reg(REG_SMOOTH_FRACTION, $urandom_range(1, 65535));
    endcase
    settings_used++;
  endtask

  task automatic test_reset_defaults();
    settings_used++;
    send_frame(16'sd0, 16'sd0);
    send_frame(16'sd32767, 16'sd0);
    send_frame(-16'sd32768, -16'sd32768);
    send_frame(16'sd0, 16'sd32767);
    send_frame(16'sd1, -16'sd1);
    settle();
  endtask

  task automatic test_full_range();
    write_reg(REG_ANGLE_SPEED, 32'hFFFF);
    write_reg(REG_PITCH_MIN, 32'hFFFF_C000);
    write_reg(REG_PITCH_MAX, 32'h0000_4000);
    write_reg(REG_ORBIT_RADIUS, 32'h7FFF_FFFF);
    write_reg(REG_TARGET_HEIGHT, 32'h7FFF_FFFF);
    write_reg(REG_SMOOTH_FRACTION, 32'hFFFF);
    settings_used++;
    // pitch runs into each limit; height saturates on the way up
    send_frame(16'sd0, 16'sd32767);
    send_frame(-16'sd32768, -16'sd32768);
    send_frame(16'sd32767, 16'sd32767);
    send_frame(-16'sd1, -16'sd1);
    settle();
    write_reg(REG_TARGET_HEIGHT, 32'h8000_0000);
    settings_used++;
    send_frame(16'sd0, -16'sd32768);
    settle();
    // zero fraction holds the position, zero speed and radius pin the target
    write_reg(REG_SMOOTH_FRACTION, 32'd0);
    send_frame(16'sd12345, -16'sd12345);
    settle();
    write_reg(REG_SMOOTH_FRACTION, 32'hFFFF);
    write_reg(REG_ANGLE_SPEED, 32'd0);
    write_reg(REG_ORBIT_RADIUS, 32'd0);
    settings_used++;
    send_frame(16'sd32767, 16'sd32767);
    settle();
  endtask

  task automatic test_crossed_limits();
    write_reg(REG_ANGLE_SPEED, 32'd20000);
    write_reg(REG_PITCH_MIN, 32'd3000);
    write_reg(REG_PITCH_MAX, 32'hFFFF_F448);
    write_reg(REG_ORBIT_RADIUS, 32'd65536000);
    write_reg(REG_TARGET_HEIGHT, 32'd0);
    write_reg(REG_SMOOTH_FRACTION, 32'd30000);
    settings_used++;
    send_frame(16'sd0, 16'sd0);
    send_frame(16'sd0, 16'sd32767);
    send_frame(16'sd5000, -16'sd32768);
    settle();
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, 32'h1234_5678);
    send_frame(-16'sd7000, 16'sd9000);
    settle();
  endtask

  task automatic test_random_traffic(input int tx_idle, input int rx_idle);
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
      pick_random_settings();
      repeat (ITEMS_PER_SETTING) send_frame(pick_stick(), pick_stick());
      settle();
    end
  endtask

  initial begin
    build_sine_table();
    load_reset_state();
    send_idle_pct = 6;
    recv_idle_pct = 47;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_full_range();
    test_crossed_limits();
    test_random_traffic(6, 47);
    test_random_traffic(47, 6);
    test_random_traffic(0, 0);
    failures += pending_positions.size();
    $display("Sent %0d joystick frames and checked %0d positions over %0d register settings.",
             frames_sent, positions_checked, settings_used);
    $display("Covered full-scale sticks, pitch clamping, crossed limits, height saturation, "
             , "ignored register indexes and stalls on both sides.");
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
